>>> rtl/core/ycr_pkg.sv
`default_nettype none

package ycr_pkg;

	typedef logic signed [9:0] term_t;
	typedef term_t term_tbl_t [256];

	localparam int Y_LO = 16;
	localparam int Y_HI = 235;
	localparam int C_LO = 16;
	localparam int C_HI = 240;
	localparam int C_MID = 128;

	localparam longint Y_NUM = 255;
	localparam longint Y_DEN = 219;
	localparam longint U1_NUM = 22593;
	localparam longint U1_DEN = 11200;
	localparam longint V1_NUM = 35751;
	localparam longint V1_DEN = 22400;
	localparam longint U2_OFS = 112000000;
	localparam longint U2_NUM = 877557;
	localparam longint V2_OFS = 327296;
	localparam longint V2_NUM = 1821057;
	localparam longint G_DEN = 2240000;

	function automatic longint clamp_sample(int s, int lo, int hi);
		longint r;
		r = s;
		if (s < lo) begin
			r = lo;
		end else if (s > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic term_tbl_t build_y_tbl();
		term_tbl_t t;
		longint n;
		for (int i = 0; i < 256; i++) begin
			n = (clamp_sample(i, Y_LO, Y_HI) - Y_LO) * Y_NUM;
			t[i] = term_t'((2 * n + Y_DEN) / (2 * Y_DEN));
		end
		return t;
	endfunction

	function automatic term_tbl_t build_u1_tbl();
		term_tbl_t t;
		longint n;
		for (int i = 0; i < 256; i++) begin
			n = (clamp_sample(i, C_LO, C_HI) - C_MID) * U1_NUM;
			if (n >= 0) begin
				t[i] = term_t'((2 * n + U1_DEN) / (2 * U1_DEN));
			end else begin
				t[i] = term_t'(-((-2 * n + U1_DEN) / (2 * U1_DEN)));
			end
		end
		return t;
	endfunction

	function automatic term_tbl_t build_v1_tbl();
		term_tbl_t t;
		longint n;
		for (int i = 0; i < 256; i++) begin
			n = (clamp_sample(i, C_LO, C_HI) - C_MID) * V1_NUM;
			if (n >= 0) begin
				t[i] = term_t'((2 * n + V1_DEN) / (2 * V1_DEN));
			end else begin
				t[i] = term_t'(-((-2 * n + V1_DEN) / (2 * V1_DEN)));
			end
		end
		return t;
	endfunction

	function automatic term_tbl_t build_u2_tbl();
		term_tbl_t t;
		longint n;
		for (int i = 0; i < 256; i++) begin
			n = U2_OFS - clamp_sample(i, C_LO, C_HI) * U2_NUM;
			if (n >= 0) begin
				t[i] = term_t'((2 * n + G_DEN) / (2 * G_DEN));
			end else begin
				t[i] = term_t'(-((-2 * n + G_DEN) / (2 * G_DEN)));
			end
		end
		return t;
	endfunction

	function automatic term_tbl_t build_v2_tbl();
		term_tbl_t t;
		longint n;
		for (int i = 0; i < 256; i++) begin
			n = V2_OFS - (clamp_sample(i, C_LO, C_HI) - C_MID) * V2_NUM;
			if (n >= 0) begin
				t[i] = term_t'((2 * n + G_DEN) / (2 * G_DEN));
			end else begin
				t[i] = term_t'(-((-2 * n + G_DEN) / (2 * G_DEN)));
			end
		end
		return t;
	endfunction

	localparam term_tbl_t Y_TBL = build_y_tbl();
	localparam term_tbl_t U1_TBL = build_u1_tbl();
	localparam term_tbl_t V1_TBL = build_v1_tbl();
	localparam term_tbl_t U2_TBL = build_u2_tbl();
	localparam term_tbl_t V2_TBL = build_v2_tbl();

	function automatic logic [7:0] sat_add(logic [7:0] a, term_t b);
		logic signed [10:0] s;
		logic [7:0] r;
		s = $signed({3'b000, a}) + $signed({b[9], b});
		if (s < 0) begin
			r = 8'd0;
		end else if (s > 255) begin
			r = 8'd255;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ycbcr_to_rgb_saturating.sv
// An accepted request sits in the input register, and its result is loaded into the output register
// once that register is free, and offered from there.
// Throughput: one pixel per cycle; the input register advances whenever the output is free.
// Table lookup, brightness and the saturating channel sums are combinational between the two.
// Reset (arst_n low, asynchronous) empties both registers and sets the brightness level (level_q) to 0.
`default_nettype none

module ycbcr_to_rgb_saturating
	import ycr_pkg::*;
#(
	parameter int BRIGHT_LEVELS = 16,
	parameter int BRIGHT_STEP = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  luma_in,
	input  wire logic [7:0]  cb_in,
	input  wire logic [7:0]  cr_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  red_out,
	output logic      [7:0]  green_out,
	output logic      [7:0]  blue_out
);

	localparam int MAX_OFS = (BRIGHT_LEVELS - 1) * BRIGHT_STEP;
	localparam int OFS_W = $clog2(MAX_OFS + 2);
	localparam int YS_W = ((OFS_W > 8) ? OFS_W : 8) + 1;
	localparam logic [6:0] LVL_MAX = 7'(BRIGHT_LEVELS - 1);

	logic [3:0] level_q;
	logic       reg0_sel;

	logic       valid_s1, valid_s2;
	logic       ready_s1, ready_s2;
	logic [7:0] luma_s1, cb_s1, cr_s1;
	logic [7:0] red_s2, green_s2, blue_s2;

	logic [3:0]      lvl_eff;
	logic [OFS_W-1:0] ofs;
	logic [YS_W-1:0]  ysum;
	logic [7:0]      ybr;
	term_t           y_term;

	assign pready = 1'b1;
	assign reg0_sel = (paddr[2] == 1'b0);
	assign prdata = reg0_sel ? {28'd0, level_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 4'd0;
		end else if (psel && penable && pwrite && pready && reg0_sel) begin
			level_q <= pwdata[3:0];
		end
	end

	assign ready_s2 = !valid_s2 || !out_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			luma_s1 <= luma_in;
			cb_s1 <= cb_in;
			cr_s1 <= cr_in;
		end
	end

	// A level above the last table entry behaves as the last entry.
	assign lvl_eff = ({3'b000, level_q} > LVL_MAX) ? LVL_MAX[3:0] : level_q;
	assign ofs = OFS_W'(lvl_eff * BRIGHT_STEP);
	assign y_term = Y_TBL[luma_s1];
	assign ysum = YS_W'(y_term[7:0]) + YS_W'(ofs);
	assign ybr = (ysum > YS_W'(255)) ? 8'd255 : ysum[7:0];

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			red_s2 <= sat_add(ybr, V1_TBL[cr_s1]);
			blue_s2 <= sat_add(ybr, U1_TBL[cb_s1]);
			green_s2 <= sat_add(sat_add(ybr, U2_TBL[cb_s1]), V2_TBL[cr_s1]);
		end
	end

	assign out_valid = valid_s2;
	assign red_out = red_s2;
	assign green_out = green_s2;
	assign blue_out = blue_s2;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty first stage");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> (valid_s2 && $stable(red_s2) && $stable(green_s2)
			&& $stable(blue_s2)))
		else $error("result changed while stalled");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_stall && !valid_s1) |=> !valid_s2)
		else $error("result repeated after it was taken");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && !paddr[2]) |=> (level_q == $past(pwdata[3:0])))
		else $error("brightness register not written");
`endif

endmodule

`default_nettype wire
